// ===== rtl/core/crab_drive_pose_integrator_core_assert.svh =====
// Assertion macros shared by the pose integrator RTL.
`ifndef CRAB_DRIVE_POSE_INTEGRATOR_CORE_ASSERT_SVH
`define CRAB_DRIVE_POSE_INTEGRATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CRAB_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CRAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crab_pkg.sv =====
// Types, constants and the arctangent table of the pose integrator.
`default_nettype none
package crab_pkg;

    typedef struct packed {
        logic signed [31:0] aim_x;
        logic signed [31:0] aim_y;
        logic signed [15:0] speed_one;
        logic signed [15:0] speed_two;
    } crab_in_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        pose_heading;
        logic [15:0]        module_angle;
    } crab_out_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } crab_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } crab_sts_t;

    localparam int CORDIC_W  = 36;
    localparam int CORDIC_ZW = 34;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SPACING = 2'd1;

    localparam logic [15:0] TICK_RESET    = 16'd1092;
    localparam logic [11:0] SPACING_RESET = 12'd50;
    localparam logic [31:0] ROBOT_X_RESET = 32'd102400;
    localparam logic [31:0] ROBOT_Y_RESET = 32'd76800;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic signed [34:0]         RAD_TO_BA   = 35'sd683565276;

    function automatic logic [CORDIC_ZW-1:0] crab_atan(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2F9;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            default: t = 32'h00000000;
        endcase
        return {2'b00, t};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/crab_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
`default_nettype none
module crab_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  crab_pkg::crab_cmd_t                        cmd,
    input  wire signed [crab_pkg::CORDIC_W-1:0]        x_init,
    input  wire signed [crab_pkg::CORDIC_W-1:0]        y_init,
    input  wire signed [crab_pkg::CORDIC_ZW-1:0]       z_init,
    output crab_pkg::crab_sts_t                        sts,
    output logic signed [crab_pkg::CORDIC_W-1:0]       x_out,
    output logic signed [crab_pkg::CORDIC_W-1:0]       y_out,
    output logic signed [crab_pkg::CORDIC_ZW-1:0]      z_out
);
    import crab_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [CORDIC_W-1:0]  x_reg, y_reg;
    logic signed [CORDIC_ZW-1:0] z_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg, done_reg, vec_reg;
    logic signed [CORDIC_W-1:0]  sx, sy;
    logic [CORDIC_ZW-1:0]        at;
    logic                        plus;

    always_comb
    begin
        sx   = x_reg >>> cnt_reg;
        sy   = y_reg >>> cnt_reg;
        at   = crab_atan(5'(cnt_reg));
        plus = vec_reg ? (y_reg > 0) : z_reg[CORDIC_ZW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= x_init;
            y_reg   <= y_init;
            z_reg   <= z_init;
            vec_reg <= cmd.vectoring;
        end
        else if (busy_reg)
        begin
            if (plus)
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + $signed(at);
            end
            else
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - $signed(at);
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule
`default_nettype wire

// ===== rtl/core/crab_divu.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module crab_divu #(
    parameter int DW = 27,
    parameter int VW = 12
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  [DW-1:0]       dividend,
    input  wire  [VW-1:0]       divisor,
    output crab_pkg::crab_sts_t sts,
    output logic [DW-1:0]       quotient
);
    import crab_pkg::*;

    localparam int CW = $clog2(DW);

    logic [VW-1:0] rem_reg, div_reg;
    logic [DW-1:0] quo_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [VW:0]   trial;
    logic          fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DW-1]};
        fits  = trial >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, div_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/core/crab_drive_pose_integrator_core.sv =====
// Top level of the crab drive pose integrator: sequencer, shared multiplier and pose state.
//
//  Channel  Direction  Handshake            Word
//  in       sink       in_valid/in_stall    crab_in_t: aim point and two wheel speeds
//  out      source     out_valid/out_stall  crab_out_t: pose and module angle
//  cfg      sink       cfg_valid/cfg_ready  cfg_index selects tick length or wheel spacing
//
// Each word runs through the shared CORDIC unit (three passes), the shared multiplier (seven
// products) and the divider; its result is then loaded into the output register, and only
// after that can the next word be taken.
// in_stall is high from acceptance until the result is loaded into the output register.
// The output register holds a result while out_stall is high; the next word is then taken.
// Reset restores the configuration registers and the pose at once; there is no clearing pass.
`default_nettype none
module crab_drive_pose_integrator_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  crab_pkg::crab_in_t                 in_word,
    output logic                               out_valid,
    input  wire                                out_stall,
    output crab_pkg::crab_out_t                out_word,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [crab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [15:0]                        cfg_data
);
    import crab_pkg::*;

    `include "crab_drive_pose_integrator_core_assert.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_VEC  = 3'd1;
    localparam logic [2:0] ST_ROTG = 3'd2;
    localparam logic [2:0] ST_ROTM = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam logic [31:0] QA_HALF = 32'd1 << (31 - ANGLE_BITS);
    localparam logic [31:0] QA_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    logic [2:0]               state_reg;
    logic [2:0]               mstep_reg;
    logic [15:0]              tick_reg;
    logic [11:0]              spacing_reg;
    logic [31:0]              robot_x_reg, robot_y_reg;
    logic [15:0]              heading_reg;
    logic signed [16:0]       sum_reg, diff_reg;
    logic                     zero_reg, flip_reg, neg_reg;
    logic [31:0]              qa_reg;
    logic signed [34:0]       cg_reg, sg_reg, cm_reg;
    logic signed [27:0]       t_reg, r_reg;
    logic [31:0]              ddx_reg, ddy_reg;
    logic [15:0]              ba_reg;
    logic signed [62:0]       prod_reg;
    logic                     out_valid_reg;
    crab_out_t                out_reg;

    logic                     accept;
    crab_cmd_t                cord_cmd;
    crab_sts_t                cord_sts, div_sts;
    logic signed [CORDIC_W-1:0]  cx0, cy0, cord_x, cord_y;
    logic signed [CORDIC_ZW-1:0] cz0, cord_z;
    logic signed [32:0]       dx, dy;
    logic signed [CORDIC_W-1:0]  dxe, dye;
    logic [31:0]              zv, qa_c, rot_a, rot_a2;
    logic                     rot_flip;
    logic signed [CORDIC_W-1:0]  flip_x, flip_y;
    logic signed [27:0]       mul_a;
    logic signed [34:0]       mul_b;
    logic signed [62:0]       rnd;
    logic [11:0]              wsp;
    logic [26:0]              mag, dividend, quot;
    logic                     div_start;
    logic                     load_out;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        dx  = 33'(in_word.aim_x) - 33'($signed(robot_x_reg));
        dy  = 33'(in_word.aim_y) - 33'($signed(robot_y_reg));
        dxe = CORDIC_W'(dx);
        dye = CORDIC_W'(dy);

        zv     = zero_reg ? 32'd0 : cord_z[31:0];
        qa_c   = (zv + QA_HALF) & QA_MASK;
        rot_a  = (state_reg == ST_VEC) ? qa_c + {heading_reg, 16'h0000} : qa_reg;
        rot_flip = rot_a[31] ^ rot_a[30];
        rot_a2 = rot_flip ? {~rot_a[31], rot_a[30:0]} : rot_a;

        cord_cmd.vectoring = (state_reg == ST_IDLE);
        cord_cmd.start     = accept
                           || ((state_reg == ST_VEC || state_reg == ST_ROTG) && cord_sts.done);
        if (state_reg == ST_IDLE)
        begin
            cx0 = dx[32] ? -dxe : dxe;
            cy0 = dx[32] ? -dye : dye;
            cz0 = dx[32] ? CORDIC_ZW'(34'h0_8000_0000) : '0;
        end
        else
        begin
            cx0 = CORDIC_GAIN;
            cy0 = '0;
            cz0 = CORDIC_ZW'($signed(rot_a2));
        end

        flip_x = flip_reg ? -cord_x : cord_x;
        flip_y = flip_reg ? -cord_y : cord_y;
    end

    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin mul_a = 28'(sum_reg);  mul_b = cg_reg; end
            3'd1:    begin mul_a = t_reg;         mul_b = 35'($signed({1'b0, tick_reg})); end
            3'd2:    begin mul_a = 28'(sum_reg);  mul_b = sg_reg; end
            3'd3:    begin mul_a = t_reg;         mul_b = 35'($signed({1'b0, tick_reg})); end
            3'd4:    begin mul_a = 28'(diff_reg); mul_b = cm_reg; end
            3'd5:    begin mul_a = t_reg;         mul_b = 35'($signed({1'b0, tick_reg})); end
            default: begin mul_a = r_reg;         mul_b = RAD_TO_BA; end
        endcase
        case (mstep_reg)
            3'd0, 3'd2, 3'd4: rnd = (prod_reg + (63'sd1 <<< 21)) >>> 22;
            3'd1, 3'd3:       rnd = (prod_reg + (63'sd1 <<< 23)) >>> 24;
            3'd5:             rnd = (prod_reg + (63'sd1 <<< 15)) >>> 16;
            default:          rnd = (prod_reg + (63'sd1 <<< 31)) >>> 32;
        endcase

        wsp       = (spacing_reg == 12'd0) ? 12'd1 : spacing_reg;
        mag       = neg_reg ? 27'(-t_reg) : t_reg[26:0];
        dividend  = mag + 27'(wsp >> 1);
        div_start = (state_reg == ST_DIV) && !div_sts.busy && !div_sts.done;
        load_out  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    end

    crab_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cord_cmd),
        .x_init (cx0),
        .y_init (cy0),
        .z_init (cz0),
        .sts    (cord_sts),
        .x_out  (cord_x),
        .y_out  (cord_y),
        .z_out  (cord_z)
    );

    crab_divu #(.DW(27), .VW(12)) u_divu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (wsp),
        .sts      (div_sts),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mstep_reg     <= 3'd0;
            tick_reg      <= TICK_RESET;
            spacing_reg   <= SPACING_RESET;
            robot_x_reg   <= ROBOT_X_RESET;
            robot_y_reg   <= ROBOT_Y_RESET;
            heading_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TICK_LENGTH:   tick_reg    <= cfg_data;
                    CFG_WHEEL_SPACING: spacing_reg <= cfg_data[11:0];
                    default:           ;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_VEC;
                    end
                end
                ST_VEC:
                begin
                    if (cord_sts.done)
                    begin
                        state_reg <= ST_ROTG;
                    end
                end
                ST_ROTG:
                begin
                    if (cord_sts.done)
                    begin
                        state_reg <= ST_ROTM;
                    end
                end
                ST_ROTM:
                begin
                    if (cord_sts.done)
                    begin
                        state_reg <= ST_MUL;
                        mstep_reg <= 3'd0;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    if (mstep_reg == 3'd5)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else if (mstep_reg == 3'd6)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                        mstep_reg <= mstep_reg + 3'd1;
                    end
                end
                ST_DIV:
                begin
                    if (div_sts.done)
                    begin
                        state_reg <= ST_MUL;
                        mstep_reg <= 3'd6;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg     <= ST_IDLE;
                        robot_x_reg   <= robot_x_reg + ddx_reg;
                        robot_y_reg   <= robot_y_reg + ddy_reg;
                        heading_reg   <= heading_reg + ba_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sum_reg  <= 17'(in_word.speed_one) + 17'(in_word.speed_two);
            diff_reg <= 17'(in_word.speed_two) - 17'(in_word.speed_one);
            zero_reg <= (dx == 33'sd0) && (dy == 33'sd0);
        end
        if ((state_reg == ST_VEC) && cord_sts.done)
        begin
            qa_reg   <= qa_c;
        end
        if (cord_cmd.start && !cord_cmd.vectoring)
        begin
            flip_reg <= rot_flip;
        end
        if ((state_reg == ST_ROTG) && cord_sts.done)
        begin
            cg_reg <= 35'(flip_x);
            sg_reg <= 35'(flip_y);
        end
        if ((state_reg == ST_ROTM) && cord_sts.done)
        begin
            cm_reg <= 35'(flip_x);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 63'(mul_a) * 63'(mul_b);
        end
        if (state_reg == ST_RND)
        begin
            case (mstep_reg)
                3'd1:    ddx_reg <= rnd[31:0];
                3'd3:    ddy_reg <= rnd[31:0];
                3'd6:    ba_reg  <= rnd[15:0];
                default: t_reg   <= rnd[27:0];
            endcase
            if (mstep_reg == 3'd5)
            begin
                neg_reg <= rnd[27];
            end
        end
        if ((state_reg == ST_DIV) && div_sts.done)
        begin
            r_reg <= neg_reg ? -28'($signed({1'b0, quot})) : 28'($signed({1'b0, quot}));
        end
        if (load_out)
        begin
            out_reg.pose_x       <= robot_x_reg + ddx_reg;
            out_reg.pose_y       <= robot_y_reg + ddy_reg;
            out_reg.pose_heading <= heading_reg + ba_reg;
            out_reg.module_angle <= 16'((qa_reg + 32'h0000_8000) >> 16);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `CRAB_ASSERT_NEXT(a_accept_starts_vector, accept, state_reg == ST_VEC,
        "Accepted word did not start the vectoring pass.")
    `CRAB_ASSERT_IMPL(a_cordic_start_idle, cord_cmd.start, !cord_sts.busy,
        "CORDIC unit restarted while busy.")
    `CRAB_ASSERT_IMPL(a_div_done_state, div_sts.done, state_reg == ST_DIV,
        "Divider finished outside the divide step.")
    `CRAB_ASSERT_IMPL(a_cordic_done_state, cord_sts.done,
        state_reg == ST_VEC || state_reg == ST_ROTG || state_reg == ST_ROTM,
        "CORDIC unit finished outside a CORDIC pass.")

endmodule
`default_nettype wire
